### hdl/abs_pkg.sv
// Package for the ABBA-BABA site score block: widths, stage payload structs,
// base-count helpers and the reciprocal table used for the fraction scaling.
// Depends on nothing; every module of the block imports it.
package abs_pkg;

   // Fixed-point format of the two fractions
   localparam int FRACTION_BITS = 16;
   localparam int FRAC_W        = FRACTION_BITS + 1;

   // Field widths
   localparam int MASK_W  = 4;
   localparam int POP_W   = 3;
   localparam int CNT_W   = 5;
   localparam int TOTAL_W = 9;
   localparam int POW2_W  = 4;
   localparam int POW3_W  = 3;

   // Dividend is count << FRACTION_BITS and stays below 2^NUM_W.
   // Odd part of the total is at most 81 < 2^7, so a reciprocal with
   // NUM_W + 7 fraction bits gives exact floor quotients.
   localparam int NUM_W        = FRACTION_BITS + CNT_W;
   localparam int RECIP_SHIFT  = NUM_W + 7;
   localparam int RECIP_W      = RECIP_SHIFT + 1;
   localparam int PROD_W       = CNT_W + RECIP_W;
   localparam int BASE_SHIFT   = RECIP_SHIFT - FRACTION_BITS;
   localparam int SHIFT_W      = $clog2(BASE_SHIFT + 9);

   localparam logic [RECIP_W-1:0] RECIP_1  = RECIP_W'(64'd1 << RECIP_SHIFT);
   localparam logic [RECIP_W-1:0] RECIP_3  =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);
   localparam logic [RECIP_W-1:0] RECIP_9  =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd8) / 64'd9);
   localparam logic [RECIP_W-1:0] RECIP_27 =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd26) / 64'd27);
   localparam logic [RECIP_W-1:0] RECIP_81 =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd80) / 64'd81);

   // Stage 1 -> stage 2 payload
   typedef struct packed {
      logic [CNT_W-1:0]  abba_cnt;
      logic [CNT_W-1:0]  baba_cnt;
      logic [POW2_W-1:0] pow2;
      logic [POW3_W-1:0] pow3;
      logic              empty;
   } count_type;

   // Stage 2 -> stage 3 payload
   typedef struct packed {
      logic [PROD_W-1:0]  abba_prod;
      logic [PROD_W-1:0]  baba_prod;
      logic [POW2_W-1:0]  pow2;
      logic [TOTAL_W-1:0] total;
      logic               empty;
   } prod_type;

   // Stage 3 result
   typedef struct packed {
      logic [FRAC_W-1:0]  abba_fraction;
      logic [FRAC_W-1:0]  baba_fraction;
      logic [TOTAL_W-1:0] total;
      logic               empty;
   } result_type;

   function automatic logic [POP_W-1:0] pop4(input logic [MASK_W-1:0] m);
      pop4 = POP_W'(m[0]) + POP_W'(m[1]) + POP_W'(m[2]) + POP_W'(m[3]);
   endfunction

   // Power-of-two exponent that a base count contributes to the total
   function automatic logic [1:0] pop_pow2(input logic [POP_W-1:0] p);
      case (p)
         3'd2:    pop_pow2 = 2'd1;
         3'd4:    pop_pow2 = 2'd2;
         default: pop_pow2 = 2'd0;
      endcase
   endfunction

   // Power-of-three exponent that a base count contributes to the total
   function automatic logic pop_pow3(input logic [POP_W-1:0] p);
      pop_pow3 = (p == 3'd3);
   endfunction

   function automatic logic [RECIP_W-1:0] recip(input logic [POW3_W-1:0] e);
      case (e)
         3'd0:    recip = RECIP_1;
         3'd1:    recip = RECIP_3;
         3'd2:    recip = RECIP_9;
         3'd3:    recip = RECIP_27;
         3'd4:    recip = RECIP_81;
         default: recip = RECIP_1;
      endcase
   endfunction

   function automatic logic [TOTAL_W-1:0] pow3_val(input logic [POW3_W-1:0] e);
      case (e)
         3'd0:    pow3_val = TOTAL_W'(1);
         3'd1:    pow3_val = TOTAL_W'(3);
         3'd2:    pow3_val = TOTAL_W'(9);
         3'd3:    pow3_val = TOTAL_W'(27);
         3'd4:    pow3_val = TOTAL_W'(81);
         default: pow3_val = TOTAL_W'(1);
      endcase
   endfunction

endpackage

### hdl/abs_count.sv
// Stage 1 of the site score pipeline: base popcounts, ABBA and BABA counts,
// and the total split into power-of-two and power-of-three exponents.
// Depends on abs_pkg.
module abs_count (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  logic [3:0]                mask_first,
   input  logic [3:0]                mask_second,
   input  logic [3:0]                mask_third,
   input  logic [3:0]                mask_fourth,
   output logic                      out_valid,
   output abs_pkg::count_type        out_data
);
   import abs_pkg::*;

   logic              valid_ff;
   count_type         data_ff;
   count_type         data_in;
   logic [POP_W-1:0]  p1, p2, p3, p4;
   logic [POP_W-1:0]  p14, p23, p13, p24, p_same;
   logic [CNT_W-1:0]  same;

   // Count set bases per taxon and per taxon pair
   always_comb begin
      p1     = pop4(mask_first);
      p2     = pop4(mask_second);
      p3     = pop4(mask_third);
      p4     = pop4(mask_fourth);
      p14    = pop4(mask_first & mask_fourth);
      p23    = pop4(mask_second & mask_third);
      p13    = pop4(mask_first & mask_third);
      p24    = pop4(mask_second & mask_fourth);
      p_same = pop4(mask_first & mask_second & mask_third & mask_fourth);
      same   = CNT_W'(p_same);

      data_in.empty = (p1 == '0) || (p2 == '0) || (p3 == '0) || (p4 == '0);
      if (data_in.empty) begin
         // Zero counts and unit divisor give zero fractions downstream
         data_in.abba_cnt = '0;
         data_in.baba_cnt = '0;
         data_in.pow2     = '0;
         data_in.pow3     = '0;
      end else begin
         data_in.abba_cnt = CNT_W'(CNT_W'(p14) * CNT_W'(p23)) - same;
         data_in.baba_cnt = CNT_W'(CNT_W'(p13) * CNT_W'(p24)) - same;
         data_in.pow2     = POW2_W'(pop_pow2(p1)) + POW2_W'(pop_pow2(p2))
                          + POW2_W'(pop_pow2(p3)) + POW2_W'(pop_pow2(p4));
         data_in.pow3     = POW3_W'(pop_pow3(p1)) + POW3_W'(pop_pow3(p2))
                          + POW3_W'(pop_pow3(p3)) + POW3_W'(pop_pow3(p4));
      end
   end

   // Advance the stage valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // Hold payload while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hdl/abs_scale.sv
// Stage 2 of the site score pipeline: multiply both counts by the reciprocal
// of the odd part of the total, and rebuild the total itself.
// Depends on abs_pkg.
module abs_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  abs_pkg::count_type  in_data,
   output logic                out_valid,
   output abs_pkg::prod_type   out_data
);
   import abs_pkg::*;

   logic                valid_ff;
   prod_type            data_ff;
   prod_type            data_in;
   logic [RECIP_W-1:0]  rcp;
   logic [TOTAL_W:0]    total_wide;

   // Scale counts; total is 3^pow3 << pow2, at most 256
   always_comb begin
      rcp               = recip(in_data.pow3);
      data_in.abba_prod = PROD_W'(in_data.abba_cnt) * PROD_W'(rcp);
      data_in.baba_prod = PROD_W'(in_data.baba_cnt) * PROD_W'(rcp);
      data_in.pow2      = in_data.pow2;
      data_in.empty     = in_data.empty;
      total_wide        = (TOTAL_W + 1)'(pow3_val(in_data.pow3)) << in_data.pow2;
      data_in.total     = in_data.empty ? '0 : total_wide[TOTAL_W-1:0];
   end

   // Advance the stage valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // Hold payload while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hdl/abs_norm.sv
// Stage 3 of the site score pipeline: drop reciprocal fraction bits and the
// power-of-two part of the total to form the truncated fractions.
// Depends on abs_pkg.
module abs_norm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  abs_pkg::prod_type    in_data,
   output logic                 out_valid,
   output abs_pkg::result_type  out_data
);
   import abs_pkg::*;

   logic                valid_ff;
   result_type          data_ff;
   result_type          data_in;
   logic [SHIFT_W-1:0]  shift;
   logic [PROD_W-1:0]   abba_q;
   logic [PROD_W-1:0]   baba_q;

   // Shift out reciprocal precision and the power-of-two divisor
   always_comb begin
      shift                 = SHIFT_W'(BASE_SHIFT) + SHIFT_W'(in_data.pow2);
      abba_q                = in_data.abba_prod >> shift;
      baba_q                = in_data.baba_prod >> shift;
      data_in.abba_fraction = abba_q[FRAC_W-1:0];
      data_in.baba_fraction = baba_q[FRAC_W-1:0];
      data_in.total         = in_data.total;
      data_in.empty         = in_data.empty;
   end

   // Advance the output valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // Hold result while the receiver stalls
   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hdl/abba_baba_site_score.sv
// ABBA-BABA site score, top level.
//
// Request channel (req_*): one alignment site per transaction, four 4-bit
// base masks (bit0 A, bit1 C, bit2 G, bit3 T). Response channel (rsp_*):
// ABBA and BABA fractions of all resolutions, unsigned with 16 fraction
// bits and truncated (65536 is 1.0), the resolution total, and an empty
// flag that is set with zero fractions when some mask has no base.
// One response per request, in order.
// An accepted request passes in turn through the three register stages
// (counting, reciprocal multiply, normalizing shift), which all move
// together; rsp_valid comes from the last. Throughput: one transaction
// per cycle while the receiver keeps rsp_ready high.
// When the receiver holds rsp_ready low with a response waiting, every
// stage holds and req_ready drops; req_ready stays high while the output
// register is empty or being taken, so no cycle is lost to a bubble.
// Reset clears all stage valid bits; the block accepts a transaction in
// the first cycle after reset is released.
// Depends on abs_pkg, abs_count, abs_scale and abs_norm.
module abba_baba_site_score (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_mask_first,
   input  logic [3:0]  req_mask_second,
   input  logic [3:0]  req_mask_third,
   input  logic [3:0]  req_mask_fourth,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [16:0] rsp_abba_fraction,
   output logic [16:0] rsp_baba_fraction,
   output logic [8:0]  rsp_resolution_total,
   output logic        rsp_empty_site
);
   import abs_pkg::*;

   logic        advance;
   logic        s1_valid, s2_valid, s3_valid;
   count_type   s1_data;
   prod_type    s2_data;
   result_type  s3_data;

   // Move the whole pipeline unless a finished response is stalled
   assign advance   = !s3_valid || rsp_ready;
   assign req_ready = advance;

   abs_count u_count (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid),
      .mask_first  (req_mask_first),
      .mask_second (req_mask_second),
      .mask_third  (req_mask_third),
      .mask_fourth (req_mask_fourth),
      .out_valid   (s1_valid),
      .out_data    (s1_data)
   );

   abs_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s1_valid),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_data  (s2_data)
   );

   abs_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s2_valid),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_data  (s3_data)
   );

   // Drive the response ports from the output stage
   assign rsp_valid            = s3_valid;
   assign rsp_abba_fraction    = s3_data.abba_fraction;
   assign rsp_baba_fraction    = s3_data.baba_fraction;
   assign rsp_resolution_total = s3_data.total;
   assign rsp_empty_site       = s3_data.empty;

endmodule
